/* hdl/odo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry package
// Shared types, register indexes and saturation helper for the differential
// drive odometry unit.
// ----------------------------------------------------------------------------
package odo_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_LEFT_MM_PER_COUNT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RIGHT_MM_PER_COUNT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEGREES_PER_MM     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LOOP_RATE_HZ       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LEFT_REVERSE       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RIGHT_REVERSE      = 3'd5;

  localparam int unsigned CfgDataW = 24;

  // Reset values of the configuration registers.
  localparam logic [23:0] LEFT_MPC_RST  = 24'd524288;
  localparam logic [23:0] RIGHT_MPC_RST = 24'd524288;
  localparam logic [23:0] DEG_MM_RST    = 24'd1048576;
  localparam logic [15:0] RATE_RST      = 16'd1000;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_STEP,
    ST_ACCUM,
    ST_FINISH
  } odo_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take a new beat: deltas, totals, clear on func
    logic scale;   // wheel counts times mm per count
    logic step;    // forward step and rotation product
    logic accum;   // rotation step and distance update
    logic finish;  // heading update and load of the output register
  } odo_cmd_t;

  // Clamp a signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage
`default_nettype wire

/* hdl/odo_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry controller
// Steps one beat through the datapath and owns the output valid flag.
// ----------------------------------------------------------------------------
module odo_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output odo_pkg::odo_cmd_t     cmd_o
);

  odo_pkg::odo_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                can_load;

  // State and output flag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= odo_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The output register can take a new result when empty or being drained.
  assign can_load = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      odo_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = odo_pkg::ST_SCALE;
        end
      end
      odo_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = odo_pkg::ST_STEP;
      end
      odo_pkg::ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = odo_pkg::ST_ACCUM;
      end
      odo_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = odo_pkg::ST_FINISH;
      end
      odo_pkg::ST_FINISH: begin
        if (can_load) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = odo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = odo_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* hdl/odo_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry datapath
// Configuration registers, wheel deltas, fixed-point scaling, accumulators
// and the output register.
// ----------------------------------------------------------------------------
module odo_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire odo_pkg::odo_cmd_t                 cmd_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [odo_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [odo_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wire logic                              func_i,
  input  wire logic [15:0]                       left_count_i,
  input  wire logic [15:0]                       right_count_i,
  output logic signed [47:0]                     distance_mm_o,
  output logic signed [47:0]                     angle_deg_o,
  output logic signed [31:0]                     forward_step_o,
  output logic signed [31:0]                     rotation_step_o,
  output logic signed [47:0]                     speed_o,
  output logic signed [47:0]                     omega_o,
  output logic signed [31:0]                     left_total_o,
  output logic signed [31:0]                     right_total_o
);

  // Configuration.
  logic [23:0] lmpc_q, rmpc_q, dpm_q;
  logic [15:0] rate_q;
  logic        lrev_q, rrev_q;

  // Working state.
  logic [15:0]        prev_l_q, prev_r_q;
  logic signed [31:0] sum_l_q, sum_r_q;
  logic signed [47:0] travel_q, heading_q, heading_d;
  logic signed [16:0] ld_q, rd_q, ld_d, rd_d;
  logic signed [41:0] lq_q, rq_q;
  logic signed [31:0] fwd_q, rot_q;
  logic signed [61:0] rprod_q;

  // Combinational intermediates.
  logic [15:0]        dl_raw, dr_raw;
  logic signed [16:0] sl, sr;
  logic signed [42:0] wsum, wdiff;
  logic signed [35:0] fwd_sh;
  logic signed [36:0] diff_sh;
  logic signed [41:0] rot_sh;
  logic signed [48:0] speed_p, omega_p;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lmpc_q <= odo_pkg::LEFT_MPC_RST;
      rmpc_q <= odo_pkg::RIGHT_MPC_RST;
      dpm_q  <= odo_pkg::DEG_MM_RST;
      rate_q <= odo_pkg::RATE_RST;
      lrev_q <= 1'b0;
      rrev_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        odo_pkg::REG_LEFT_MM_PER_COUNT:  lmpc_q <= cfg_data_i;
        odo_pkg::REG_RIGHT_MM_PER_COUNT: rmpc_q <= cfg_data_i;
        odo_pkg::REG_DEGREES_PER_MM:     dpm_q  <= cfg_data_i;
        odo_pkg::REG_LOOP_RATE_HZ:       rate_q <= cfg_data_i[15:0];
        odo_pkg::REG_LEFT_REVERSE:       lrev_q <= cfg_data_i[0];
        odo_pkg::REG_RIGHT_REVERSE:      rrev_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Wrap-safe signed wheel deltas with polarity.
  always_comb begin
    dl_raw = left_count_i - prev_l_q;
    dr_raw = right_count_i - prev_r_q;
    sl     = {dl_raw[15], dl_raw};
    sr     = {dr_raw[15], dr_raw};
    ld_d   = lrev_q ? -sl : sl;
    rd_d   = rrev_q ? -sr : sr;
  end

  // Wheel sum and difference shifts, rotation scaling, next heading and rate products.
  always_comb begin
    wsum    = 43'(lq_q) + 43'(rq_q);
    wdiff   = 43'(rq_q) - 43'(lq_q);
    fwd_sh  = 36'(wsum >>> 7);
    diff_sh = 37'(wdiff >>> 6);
    rot_sh  = 42'(rprod_q >>> 20);
    heading_d = heading_q + 48'(rot_q);
    speed_p = fwd_q * $signed({1'b0, rate_q});
    omega_p = rot_q * $signed({1'b0, rate_q});
  end

  // Beat intake: previous counts, totals, and a clear on func.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q  <= '0;
      prev_r_q  <= '0;
      sum_l_q   <= '0;
      sum_r_q   <= '0;
      travel_q  <= '0;
      heading_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        prev_l_q <= left_count_i;
        prev_r_q <= right_count_i;
        if (func_i) begin
          sum_l_q   <= '0;
          sum_r_q   <= '0;
          travel_q  <= '0;
          heading_q <= '0;
        end else begin
          sum_l_q <= sum_l_q + 32'(ld_d);
          sum_r_q <= sum_r_q + 32'(rd_d);
        end
      end
      if (cmd_i.accum) begin
        travel_q <= travel_q + 48'(fwd_q);
      end
      if (cmd_i.finish) begin
        heading_q <= heading_d;
      end
    end
  end

  // Arithmetic pipeline registers; a cleared beat runs with zero deltas.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ld_q <= func_i ? '0 : ld_d;
      rd_q <= func_i ? '0 : rd_d;
    end
    if (cmd_i.scale) begin
      lq_q <= 42'(ld_q * $signed({1'b0, lmpc_q}));
      rq_q <= 42'(rd_q * $signed({1'b0, rmpc_q}));
    end
    if (cmd_i.step) begin
      fwd_q   <= odo_pkg::sat32(64'(fwd_sh));
      rprod_q <= 62'(diff_sh * $signed({1'b0, dpm_q}));
    end
    if (cmd_i.accum) begin
      rot_q <= odo_pkg::sat32(64'(rot_sh));
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      distance_mm_o   <= travel_q;
      angle_deg_o     <= heading_d;
      forward_step_o  <= fwd_q;
      rotation_step_o <= rot_q;
      speed_o         <= speed_p[47:0];
      omega_o         <= omega_p[47:0];
      left_total_o    <= sum_l_q;
      right_total_o   <= sum_r_q;
    end
  end

endmodule
`default_nettype wire

/* hdl/differential_drive_odometry_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: an accepted input beat walks the scale, step, accumulate and
// finish stages of the shared datapath in order; finish waits while the held
// result is stalled. A new beat is taken only when the sequencer is idle.
// Reset: asynchronous; configuration returns to its defaults and all counts,
// totals, distance and heading clear to zero.
// ----------------------------------------------------------------------------
// Differential drive odometry unit
// Per-tick wheel odometry: count totals, distance, heading, steps and rates.
// ----------------------------------------------------------------------------
module differential_drive_odometry_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [odo_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [odo_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         func_i,
  input  wire logic [15:0]                  left_count_i,
  input  wire logic [15:0]                  right_count_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [47:0]                distance_mm_o,
  output logic signed [47:0]                angle_deg_o,
  output logic signed [31:0]                forward_step_o,
  output logic signed [31:0]                rotation_step_o,
  output logic signed [47:0]                speed_o,
  output logic signed [47:0]                omega_o,
  output logic signed [31:0]                left_total_o,
  output logic signed [31:0]                right_total_o
);

  odo_pkg::odo_cmd_t cmd;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  odo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  odo_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .left_count_i    (left_count_i),
    .right_count_i   (right_count_i),
    .distance_mm_o   (distance_mm_o),
    .angle_deg_o     (angle_deg_o),
    .forward_step_o  (forward_step_o),
    .rotation_step_o (rotation_step_o),
    .speed_o         (speed_o),
    .omega_o         (omega_o),
    .left_total_o    (left_total_o),
    .right_total_o   (right_total_o)
  );

endmodule
`default_nettype wire
